// ===== rtl/core/plcl_pkg.sv =====
// ----------------------------------------------------------------------------
// plcl_pkg: shared types and constants of the point list component labeler
// Label and field widths, controller states, and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package plcl_pkg;

  localparam int DEF_MAX_POINTS = 1024;
  localparam int DEF_COORD_BITS = 12;

  localparam int COORD_IN_W   = 12;
  localparam int LABEL_W      = 10;
  localparam int LABEL_N      = 1 << LABEL_W;
  localparam logic [LABEL_W-1:0] LABEL_MAX = '1;

  // Merge marks in the flag memory carry the item epoch of this width.
  localparam int EP_W = 8;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_RELABEL,
    ST_FINISH
  } plcl_state_t;

  typedef struct packed {
    logic load;
    logic relabel_init;
    logic run_scan;
    logic run_relabel;
    logic finish;
    logic clr_run;
  } plcl_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pass_done;
    logic merged;
    logic out_free;
    logic clr_last;
    logic ep_last;
  } plcl_stat_t;

endpackage

// ===== rtl/core/plcl_ctrl.sv =====
// ----------------------------------------------------------------------------
// plcl_ctrl: sequencing controller
// Steps each word through load, neighbor scan (skipped on an empty or full
// store), optional relabel and hand-off; runs the merge-flag clearing sweep.
// ----------------------------------------------------------------------------
module plcl_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output plcl_pkg::plcl_cmd_t  cmd,
  input  plcl_pkg::plcl_stat_t stat
);
  import plcl_pkg::*;

  plcl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_run = 1'b1;
        if (stat.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat.full || stat.empty) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.run_scan = 1'b1;
        if (stat.pass_done) begin
          if (stat.merged) begin
            cmd.relabel_init = 1'b1;
            state_nxt        = ST_RELABEL;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_RELABEL: begin
        cmd.run_relabel = 1'b1;
        if (stat.pass_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = stat.ep_last ? ST_CLEAR : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== rtl/core/plcl_dp.sv =====
// ----------------------------------------------------------------------------
// plcl_dp: point store and labeling datapath
// Holds the point and label memories, the merge-flag memory, the scan
// pipeline with its neighbor test, and the result register.
// ----------------------------------------------------------------------------
module plcl_dp #(
  parameter int MAX_POINTS = plcl_pkg::DEF_MAX_POINTS,
  parameter int COORD_BITS = plcl_pkg::DEF_COORD_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  plcl_pkg::plcl_cmd_t             cmd,
  output plcl_pkg::plcl_stat_t            stat,
  input  logic [plcl_pkg::COORD_IN_W-1:0] in_x,
  input  logic [plcl_pkg::COORD_IN_W-1:0] in_y,
  input  logic                            in_new_set,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [plcl_pkg::LABEL_W-1:0]    out_label,
  output logic                            out_ovf
);
  import plcl_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int CW    = COORD_BITS;

  logic [CW-1:0] x_mem [MAX_POINTS];
  logic [CW-1:0] y_mem [MAX_POINTS];
  logic [LABEL_W-1:0] lab_mem [MAX_POINTS];
  logic [EP_W-1:0] flag_mem [LABEL_N];

  logic [CW-1:0]      px_in, py_in;
  logic [CW-1:0]      px_r, px_nxt, py_r, py_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt, idx_r, idx_nxt;
  logic               v1_r, v1_nxt, v2_r, v2_nxt;
  logic [IDX_W-1:0]   idx1_r, idx2_r;
  logic [CW-1:0]      mx_r, my_r;
  logic [LABEL_W-1:0] ml_r, lab2_r;
  logic               nb2_r;
  logic [EP_W-1:0]    fl_r;
  logic               found_r, found_nxt, merged_r, merged_nxt;
  logic [LABEL_W-1:0] final_r, final_nxt, max_r, max_nxt;
  logic [EP_W-1:0]    ep_r, ep_nxt;
  logic               lw_v_r, lw_v_nxt;
  logic [LABEL_W-1:0] lw_lab_r;
  logic [LABEL_W-1:0] clr_r, clr_nxt;
  logic               out_v_r, out_v_nxt, out_ovf_r;
  logic [LABEL_W-1:0] out_lab_r;

  logic               issue, nb_c, in_set_c, new_lab_c, rl_we, append;
  logic               dx_ok, dy_ok;
  logic [LABEL_W-1:0] res_lab;
  logic               lab_we, fl_we;
  logic [IDX_W-1:0]   lab_wa;
  logic [LABEL_W-1:0] lab_wd, fl_wa;
  logic [EP_W-1:0]    fl_wd;

  if (CW <= COORD_IN_W) begin : g_trunc
    assign px_in = in_x[CW-1:0];
    assign py_in = in_y[CW-1:0];
  end else begin : g_ext
    assign px_in = {{(CW-COORD_IN_W){1'b0}}, in_x};
    assign py_in = {{(CW-COORD_IN_W){1'b0}}, in_y};
  end

  assign dx_ok = (mx_r == px_r)
              || (({1'b0, mx_r} + (CW+1)'(1)) == {1'b0, px_r})
              || (({1'b0, px_r} + (CW+1)'(1)) == {1'b0, mx_r});
  assign dy_ok = (my_r == py_r)
              || (({1'b0, my_r} + (CW+1)'(1)) == {1'b0, py_r})
              || (({1'b0, py_r} + (CW+1)'(1)) == {1'b0, my_r});
  assign nb_c  = dx_ok && dy_ok && !((mx_r == px_r) && (my_r == py_r));

  assign issue     = (cmd.run_scan || cmd.run_relabel) && (idx_r < cnt_r);
  assign in_set_c  = (fl_r == ep_r) || (lw_v_r && (lw_lab_r == lab2_r));
  assign new_lab_c = cmd.run_scan && v2_r && nb2_r && !in_set_c;
  assign rl_we     = cmd.run_relabel && v2_r && (fl_r == ep_r) && (lab2_r != final_r);
  assign append    = cmd.finish && !stat.full;

  always_comb begin
    if (cnt_r == '0) begin
      res_lab = '0;
    end else if (found_r) begin
      res_lab = final_r;
    end else if (max_r == LABEL_MAX) begin
      res_lab = LABEL_MAX;
    end else begin
      res_lab = max_r + LABEL_W'(1);
    end
  end

  assign stat.full      = (cnt_r == CNT_W'(MAX_POINTS));
  assign stat.empty     = (cnt_r == '0);
  assign stat.pass_done = (idx_r >= cnt_r) && !v1_r && !v2_r;
  assign stat.merged    = merged_r;
  assign stat.out_free  = !out_v_r || out_tready;
  assign stat.clr_last  = (clr_r == LABEL_MAX);
  assign stat.ep_last   = (ep_r == '1);

  always_comb begin
    lab_we = append || rl_we;
    lab_wa = append ? cnt_r[IDX_W-1:0] : idx2_r;
    lab_wd = append ? res_lab : final_r;
    fl_we  = cmd.clr_run || new_lab_c;
    fl_wa  = cmd.clr_run ? clr_r : lab2_r;
    fl_wd  = cmd.clr_run ? '0 : ep_r;
  end

  always_comb begin
    px_nxt     = px_r;
    py_nxt     = py_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    found_nxt  = found_r;
    merged_nxt = merged_r;
    final_nxt  = final_r;
    max_nxt    = max_r;
    ep_nxt     = ep_r;
    clr_nxt    = clr_r;
    v1_nxt     = issue;
    v2_nxt     = v1_r;
    lw_v_nxt   = new_lab_c;
    out_v_nxt  = out_tready ? 1'b0 : out_v_r;

    if (cmd.load) begin
      px_nxt     = px_in;
      py_nxt     = py_in;
      cnt_nxt    = in_new_set ? '0 : cnt_r;
      idx_nxt    = '0;
      found_nxt  = 1'b0;
      merged_nxt = 1'b0;
      max_nxt    = '0;
    end
    if (cmd.relabel_init) begin
      idx_nxt = '0;
    end else if (issue) begin
      idx_nxt = idx_r + CNT_W'(1);
    end
    if (cmd.run_scan && v2_r) begin
      if (lab2_r > max_r) begin
        max_nxt = lab2_r;
      end
      if (nb2_r && !in_set_c) begin
        final_nxt  = lab2_r;
        found_nxt  = 1'b1;
        merged_nxt = merged_r || found_r;
      end
    end
    if (cmd.finish) begin
      out_v_nxt = 1'b1;
      ep_nxt    = ep_r + EP_W'(1);
      if (append) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
    if (cmd.clr_run) begin
      clr_nxt = clr_r + LABEL_W'(1);
      if (stat.clr_last) begin
        ep_nxt = EP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      idx_r    <= '0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      found_r  <= 1'b0;
      merged_r <= 1'b0;
      ep_r     <= EP_W'(1);
      lw_v_r   <= 1'b0;
      clr_r    <= '0;
      out_v_r  <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      idx_r    <= idx_nxt;
      v1_r     <= v1_nxt;
      v2_r     <= v2_nxt;
      found_r  <= found_nxt;
      merged_r <= merged_nxt;
      ep_r     <= ep_nxt;
      lw_v_r   <= lw_v_nxt;
      clr_r    <= clr_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r     <= px_nxt;
    py_r     <= py_nxt;
    final_r  <= final_nxt;
    max_r    <= max_nxt;
    idx1_r   <= idx_r[IDX_W-1:0];
    idx2_r   <= idx1_r;
    lab2_r   <= ml_r;
    nb2_r    <= nb_c;
    lw_lab_r <= lab2_r;
    if (cmd.finish) begin
      out_lab_r <= append ? res_lab : '0;
      out_ovf_r <= stat.full;
    end
  end

  always_ff @(posedge clk) begin
    if (append) begin
      x_mem[cnt_r[IDX_W-1:0]] <= px_r;
      y_mem[cnt_r[IDX_W-1:0]] <= py_r;
    end
    mx_r <= x_mem[idx_r[IDX_W-1:0]];
    my_r <= y_mem[idx_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (lab_we) begin
      lab_mem[lab_wa] <= lab_wd;
    end
    ml_r <= lab_mem[idx_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (fl_we) begin
      flag_mem[fl_wa] <= fl_wd;
    end
    fl_r <= flag_mem[ml_r];
  end

  assign out_tvalid = out_v_r;
  assign out_label  = out_lab_r;
  assign out_ovf    = out_ovf_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_POINTS))
    else $error("Point count exceeds the store depth.");

  a_merge_found: assert property (@(posedge clk) disable iff (!rst_n)
    merged_r |-> found_r)
    else $error("Merge recorded without a neighbor group.");

  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && !stat.full |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("Stored point was not counted.");

  a_drop_word: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && stat.full |=> out_v_r && out_ovf_r && (out_lab_r == '0))
    else $error("Dropped point gave a wrong result word.");

  a_epoch_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.clr_run |-> ep_r != '0)
    else $error("Merge epoch matches cleared flags.");

endmodule

// ===== rtl/core/point_list_component_labeler.sv =====
// ----------------------------------------------------------------------------
// point_list_component_labeler: 8-connected labeling over a point list
// An input word is checked in one scan over the stored points, followed
// by a second, relabel pass when the point joins two or more groups.
// Throughput: one word at a time; the scan over the point memory sets it.
// After every 255 words, and after reset, a merge-flag clearing sweep runs
// before the next input word is accepted; reset empties the store.
// ----------------------------------------------------------------------------
module point_list_component_labeler #(
  parameter int MAX_POINTS = plcl_pkg::DEF_MAX_POINTS,
  parameter int COORD_BITS = plcl_pkg::DEF_COORD_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [plcl_pkg::IN_TDATA_W-1:0]  in_tdata,  // point_x, point_y
  input  logic                             in_tuser,  // new_set
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [plcl_pkg::OUT_TDATA_W-1:0] out_tdata, // group_label
  output logic                             out_tuser  // overflow
);
  import plcl_pkg::*;

  plcl_cmd_t          cmd;
  plcl_stat_t         stat;
  logic [LABEL_W-1:0] label;

  plcl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  plcl_dp #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_x       (in_tdata[COORD_IN_W-1:0]),
    .in_y       (in_tdata[2*COORD_IN_W-1:COORD_IN_W]),
    .in_new_set (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_label  (label),
    .out_ovf    (out_tuser)
  );

  assign out_tdata = {{(OUT_TDATA_W-LABEL_W){1'b0}}, label};

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for point_list_component_labeler
// Streams pixel coordinates into the labeler and predicts each group label
// with a behavioral copy of the point list. It covers the coordinate extremes,
// duplicate points, group merges, filling the list to overflow, a long output
// stall, and random clustered point sets, with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import plcl_pkg::*;

  localparam int RANDOM_ITEMS = 290;
  localparam int HOLD_CYCLES  = 3000;
  localparam int DRAIN_CYCLES = 2 * DEF_MAX_POINTS + 64;
  localparam int CYCLE_LIMIT  = 12_000_000;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic               dropped;
  } label_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  logic [COORD_IN_W-1:0] pts_x [DEF_MAX_POINTS];
  logic [COORD_IN_W-1:0] pts_y [DEF_MAX_POINTS];
  logic [LABEL_W-1:0]    pts_label [DEF_MAX_POINTS];
  int                    pts_count = 0;

  label_result_t pending_labels[$];
  int            mismatches = 0;
  int            cycle_count = 0;
  int            idle_pct = 10;
  int            hold_req = 0;
  int            hold_seen = 0;
  int            hold_left = 0;

  point_list_component_labeler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // The receiver stalls at random, or for a long stretch when asked to.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen  <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    label_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_labels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: label %0d overflow %0b", out_tdata, out_tuser);
      end else begin
        want = pending_labels.pop_front();
        if (out_tdata != OUT_TDATA_W'(want.label) || out_tuser != want.dropped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected label %0d overflow %0b, got label %0d overflow %0b",
                     want.label, want.dropped, out_tdata, out_tuser);
        end
      end
    end
  end

  function automatic label_result_t label_point(input logic [COORD_IN_W-1:0] px,
                                                input logic [COORD_IN_W-1:0] py,
                                                input logic ns);
    label_result_t      r;
    logic [LABEL_W-1:0] group;
    logic [LABEL_W-1:0] top;
    logic [LABEL_W-1:0] g;
    bit                 found;
    int                 dx;
    int                 dy;
    r = '0;
    group = '0;
    top = '0;
    found = 1'b0;
    if (ns)
      pts_count = 0;
    if (pts_count >= DEF_MAX_POINTS) begin
      r.dropped = 1'b1;
      return r;
    end
    for (int i = 0; i < pts_count; i++) begin
      dx = int'(px) - int'(pts_x[i]);
      dy = int'(py) - int'(pts_y[i]);
      if (dx >= -1 && dx <= 1 && dy >= -1 && dy <= 1 && !(dx == 0 && dy == 0)) begin
        g = pts_label[i];
        // Touching a second group folds the group found so far into it.
        if (found && g != group) begin
          for (int j = 0; j < pts_count; j++)
            if (pts_label[j] == group)
              pts_label[j] = g;
        end
        group = g;
        found = 1'b1;
      end
    end
    if (pts_count == 0) begin
      r.label = '0;
    end else if (!found) begin
      for (int j = 0; j < pts_count; j++)
        if (pts_label[j] > top)
          top = pts_label[j];
      r.label = (top == LABEL_MAX) ? LABEL_MAX : top + 1'b1;
    end else begin
      r.label = group;
    end
    pts_x[pts_count] = px;
    pts_y[pts_count] = py;
    pts_label[pts_count] = r.label;
    pts_count++;
    return r;
  endfunction

  task automatic send_point(input int x, input int y, input bit ns);
    logic [COORD_IN_W-1:0] px;
    logic [COORD_IN_W-1:0] py;
    px = COORD_IN_W'(x);
    py = COORD_IN_W'(y);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {py, px};
    in_tuser  <= ns;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    pending_labels.push_back(label_point(px, py, ns));
  endtask

  task automatic apply_reset();
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  endtask

  task automatic test_corners();
    send_point(0, 0, 1'b1);
    send_point(4095, 4095, 1'b0);
    send_point(4095, 0, 1'b0);
    send_point(0, 4095, 1'b0);
    send_point(1, 1, 1'b0);
    send_point(4094, 4094, 1'b0);
    send_point(4095, 0, 1'b0);
    send_point(0, 2048, 1'b0);
    send_point(4095, 2048, 1'b0);
    send_point(2048, 0, 1'b0);
    send_point(2048, 4095, 1'b0);
  endtask

  task automatic test_merges();
    send_point(10, 10, 1'b1);
    send_point(12, 10, 1'b0);
    send_point(11, 10, 1'b0);
    send_point(20, 20, 1'b0);
    send_point(22, 22, 1'b0);
    send_point(24, 20, 1'b0);
    send_point(21, 21, 1'b0);
    send_point(23, 21, 1'b0);
    send_point(11, 11, 1'b0);
    send_point(30, 30, 1'b0);
    send_point(11, 11, 1'b1);
    send_point(11, 12, 1'b0);
  endtask

  // Isolated points on an even grid fill the list, then further points drop until a new set begins.
  task automatic test_fill_and_overflow();
    idle_pct = 0;
    for (int i = 0; i < DEF_MAX_POINTS; i++)
      send_point((i % 64) * 2, (i / 64) * 2, i == 0);
    idle_pct = 10;
    send_point(1, 1, 1'b0);
    send_point(4095, 4095, 1'b0);
    send_point($urandom_range(4095), $urandom_range(4095), 1'b0);
    send_point(5, 5, 1'b1);
  endtask

  task automatic test_output_stall();
    hold_req = hold_req + 1;
    for (int i = 0; i < 12; i++)
      send_point(300 + $urandom_range(3), 700 + $urandom_range(3), i == 0);
  endtask

  task automatic test_random_sets();
    int sent;
    int len;
    int w;
    int ox;
    int oy;
    bit ns;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(99) < 10) begin
        send_point($urandom_range(4095), $urandom_range(4095), 1'($urandom_range(1)));
        sent++;
      end else begin
        len = $urandom_range(1, 30);
        w = $urandom_range(2, 10);
        case ($urandom_range(3))
          0: ox = 0;
          1: ox = 4095 - w;
          default: ox = $urandom_range(4095 - w);
        endcase
        case ($urandom_range(3))
          0: oy = 0;
          1: oy = 4095 - w;
          default: oy = $urandom_range(4095 - w);
        endcase
        ns = ($urandom_range(9) != 0);
        for (int k = 0; k < len; k++)
          send_point(ox + $urandom_range(w), oy + $urandom_range(w), (k == 0) ? ns : 1'b0);
        sent += len;
      end
    end
  endtask

  task automatic finish_run();
    in_tvalid <= 1'b0;
    while (pending_labels.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    apply_reset();
    test_corners();
    test_merges();
    test_fill_and_overflow();
    test_output_stall();
    test_random_sets();
    finish_run();
    if (mismatches == 0 && pending_labels.size() == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule

// ===== point_list_component_labeler.f =====
rtl/core/plcl_pkg.sv
rtl/core/plcl_ctrl.sv
rtl/core/plcl_dp.sv
rtl/core/point_list_component_labeler.sv
tb/testbench.sv
